### design/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/dcc_tse_pkg.sv
// Types and constants of the DCC track signal encoder.
`timescale 1ns / 1ps
`default_nettype none
package dcc_tse_pkg;

	// Configuration port
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [1:0] REG_SHORT_HALF    = 2'd0;
	localparam logic [1:0] REG_LONG_HALF     = 2'd1;
	localparam logic [1:0] REG_PREAMBLE_LEN  = 2'd2;

	localparam logic [7:0] SHORT_HALF_RST    = 8'd115;
	localparam logic [7:0] LONG_HALF_RST     = 8'd199;
	localparam logic [7:0] PREAMBLE_LEN_RST  = 8'd17;
	localparam logic [7:0] PREAMBLE_MIN      = 8'd3;

	// Item kinds
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] byte_value;
		logic       byte_last;
	} item_t;

	typedef struct packed {
		logic [7:0] timer_compare;
		logic       track_level;
		logic       request_packet;
		logic       packet_taken;
		logic       packet_repeated;
		logic       load_overflow;
	} result_t;

endpackage
`default_nettype wire

### design/dcc_track_signal_encoder.sv
// DCC track signal encoder: packet staging, bit framing and half-period timing.
//
//  channel   direction  handshake                 payload
//  item      in         item_valid / item_stall   item   (kind, byte_value, byte_last)
//  result    out        result_valid / result_stall  result (timer, level, flags)
//  config    in         APB psel/penable/pwrite   paddr, pwdata, prdata (8-bit regs)
//
//  One transaction per cycle while item_stall is low; its result sits in the output register in the next cycle.
//  item_stall rises only while a result is held and result_stall is high.
//  Packet bytes live in a two-bank RAM (2 x PACKET_MAX_BYTES); the active byte is
//  prefetched into a read register, always settled before the tick that uses it.
//  Reset clears all control state; the RAM is not cleared (only written bytes are read).
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dcc_track_signal_encoder #(
	parameter int PACKET_MAX_BYTES = 8
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// item channel
	input  wire                              item_valid,
	output logic                             item_stall,
	input  dcc_tse_pkg::item_t               item,
	// result channel
	output logic                             result_valid,
	input  wire                              result_stall,
	output dcc_tse_pkg::result_t             result,
	// APB configuration
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire [dcc_tse_pkg::ADDR_W-1:0]    paddr,
	input  wire [dcc_tse_pkg::DATA_W-1:0]    pwdata,
	output logic [dcc_tse_pkg::DATA_W-1:0]   prdata,
	output logic                             pready
);
	import dcc_tse_pkg::*;

	// Widths that follow from the packet size
	localparam int DEPTH = 2 * PACKET_MAX_BYTES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(PACKET_MAX_BYTES + 1);   // byte counts 0..max
	localparam int BW    = $clog2(8 * PACKET_MAX_BYTES + 1); // bit position
	localparam int IW    = BW - 3;                          // byte index
	localparam logic [CW-1:0] MAX_CNT = CW'(PACKET_MAX_BYTES);
	localparam logic [AW-1:0] BANK1_BASE = AW'(PACKET_MAX_BYTES);

	// Frame phase codes
	localparam logic [1:0] PH_PREAMBLE = 2'd0;
	localparam logic [1:0] PH_START    = 2'd1;
	localparam logic [1:0] PH_DATA     = 2'd2;

	// Configuration registers
	logic [7:0] short_half_q, long_half_q, preamble_len_q;
	logic       cfg_wr;
	logic [1:0] cfg_idx;

	// Encoder state
	logic          bank_q;
	logic [CW-1:0] active_len_q;
	logic [CW-1:0] staged_cnt_q;
	logic          staged_ready_q;
	logic [BW-1:0] bit_pos_q;
	logic [7:0]    pre_cnt_q;
	logic [1:0]    phase_q;
	logic          pending_bit_q;
	logic          second_half_q;
	logic          level_q;

	// Next-state values
	logic          bank_d;
	logic [CW-1:0] active_len_d;
	logic [CW-1:0] staged_cnt_d;
	logic          staged_ready_d;
	logic [BW-1:0] bit_pos_d;
	logic [7:0]    pre_cnt_d;
	logic [1:0]    phase_d;
	logic          pending_bit_d;
	logic          second_half_d;
	logic          level_d;
	result_t       res_d;

	// Packet RAM
	logic [7:0]    pkt_mem [DEPTH];
	logic [7:0]    rd_byte_q;
	logic [AW-1:0] wr_addr, rd_addr;
	logic          wr_en;
	logic [CW-1:0] cnt_base;
	logic [IW-1:0] byte_idx;
	logic          last_byte;

	// Output register
	logic    result_valid_q;
	result_t result_q;
	logic    item_acc;

	logic [7:0] eff_len;

	// ---------------------------------------------------------------
	// APB: writes land on the access phase, reads are plain muxes
	// ---------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_half_q   <= SHORT_HALF_RST;
			long_half_q    <= LONG_HALF_RST;
			preamble_len_q <= PREAMBLE_LEN_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_SHORT_HALF:   short_half_q   <= pwdata[7:0];
				REG_LONG_HALF:    long_half_q    <= pwdata[7:0];
				REG_PREAMBLE_LEN: preamble_len_q <= pwdata[7:0];
				default: ;  // unmapped address, write dropped
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			REG_SHORT_HALF:   prdata[7:0] = short_half_q;
			REG_LONG_HALF:    prdata[7:0] = long_half_q;
			REG_PREAMBLE_LEN: prdata[7:0] = preamble_len_q;
			default:          prdata      = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Handshake: one-deep output register
	// ---------------------------------------------------------------
	assign item_stall   = result_valid_q & result_stall;
	assign item_acc     = item_valid & ~item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// ---------------------------------------------------------------
	// Address and helper terms
	// ---------------------------------------------------------------
	// A load after a completed packet restarts staging from byte zero.
	assign cnt_base = staged_ready_q ? '0 : staged_cnt_q;
	// Loads always target the spare bank.
	assign wr_addr  = bank_q ? AW'(cnt_base) : BANK1_BASE + AW'(cnt_base);
	assign byte_idx = bit_pos_q[BW-1:3];
	assign rd_addr  = bank_q ? BANK1_BASE + AW'(byte_idx) : AW'(byte_idx);
	assign last_byte = ((CW+1)'(byte_idx) + (CW+1)'(1)) >= (CW+1)'(active_len_q);
	// Short preamble settings clamp to the minimum.
	assign eff_len  = (preamble_len_q < PREAMBLE_MIN) ? PREAMBLE_MIN : preamble_len_q;

	// ---------------------------------------------------------------
	// Next state and result for the incoming transaction
	// ---------------------------------------------------------------
	always_comb begin
		logic [CW-1:0] new_len;
		new_len        = active_len_q;
		res_d          = '0;
		res_d.track_level = level_q;
		wr_en          = 1'b0;
		bank_d         = bank_q;
		active_len_d   = active_len_q;
		staged_cnt_d   = staged_cnt_q;
		staged_ready_d = staged_ready_q;
		bit_pos_d      = bit_pos_q;
		pre_cnt_d      = pre_cnt_q;
		phase_d        = phase_q;
		pending_bit_d  = pending_bit_q;
		second_half_d  = second_half_q;
		level_d        = level_q;

		if (item.kind == KIND_LOAD) begin
			staged_cnt_d = cnt_base;
			if (cnt_base < MAX_CNT) begin
				wr_en        = 1'b1;
				staged_cnt_d = cnt_base + CW'(1);
			end else begin
				res_d.load_overflow = 1'b1;
			end
			// byte_last completes the packet even if this byte was dropped
			staged_ready_d = item.byte_last & (staged_cnt_d != '0);
		end else begin
			// timer length comes from the bit decided one period earlier
			res_d.timer_compare = pending_bit_q ? short_half_q : long_half_q;
			level_d             = ~level_q;
			res_d.track_level   = ~level_q;
			second_half_d       = ~second_half_q;
			if (second_half_q) begin
				unique case (phase_q)
					PH_PREAMBLE: begin
						pending_bit_d = 1'b1;
						if (pre_cnt_q == eff_len - 8'd2) begin
							res_d.request_packet = 1'b1;
							pre_cnt_d            = pre_cnt_q + 8'd1;
						end else if (pre_cnt_q >= eff_len - 8'd1) begin
							// end of preamble; also catches a lowered register
							pre_cnt_d = '0;
							if (staged_ready_q) begin
								bank_d             = ~bank_q;
								new_len            = staged_cnt_q;
								active_len_d       = staged_cnt_q;
								staged_cnt_d       = '0;
								staged_ready_d     = 1'b0;
								res_d.packet_taken = 1'b1;
							end else if (active_len_q != '0) begin
								res_d.packet_repeated = 1'b1;
							end
							// no packet at all: preamble simply restarts
							if (new_len != '0) begin
								phase_d   = PH_START;
								bit_pos_d = '0;
							end
						end else begin
							pre_cnt_d = pre_cnt_q + 8'd1;
						end
					end
					PH_START: begin
						pending_bit_d = 1'b0;
						phase_d       = PH_DATA;
					end
					default: begin
						// data bits, MSB first, from the prefetched byte
						pending_bit_d = rd_byte_q[3'd7 - bit_pos_q[2:0]];
						if (bit_pos_q[2:0] == 3'd7) begin
							phase_d = last_byte ? PH_PREAMBLE : PH_START;
						end
						bit_pos_d = bit_pos_q + BW'(1);
					end
				endcase
			end
		end
	end

	// ---------------------------------------------------------------
	// State registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q         <= 1'b0;
			active_len_q   <= '0;
			staged_cnt_q   <= '0;
			staged_ready_q <= 1'b0;
			bit_pos_q      <= '0;
			pre_cnt_q      <= '0;
			phase_q        <= PH_PREAMBLE;
			pending_bit_q  <= 1'b0;
			second_half_q  <= 1'b0;
			level_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= item_acc | (result_valid_q & result_stall);
			if (item_acc) begin
				bank_q         <= bank_d;
				active_len_q   <= active_len_d;
				staged_cnt_q   <= staged_cnt_d;
				staged_ready_q <= staged_ready_d;
				bit_pos_q      <= bit_pos_d;
				pre_cnt_q      <= pre_cnt_d;
				phase_q        <= phase_d;
				pending_bit_q  <= pending_bit_d;
				second_half_q  <= second_half_d;
				level_q        <= level_d;
			end
		end
	end

	// Result payload, no reset needed
	always_ff @(posedge clk) begin
		if (item_acc) begin
			result_q <= res_d;
		end
	end

	// ---------------------------------------------------------------
	// Packet RAM: one write port, one registered read port.
	// The read address tracks the active bank and byte; it settles
	// before the tick that decides a data bit.
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (item_acc && wr_en) begin
			pkt_mem[wr_addr] <= item.byte_value;
		end
		rd_byte_q <= pkt_mem[rd_addr];
	end

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`ASSERT_IMPLIES(a_ready_has_bytes, clk, arst_n, staged_ready_q, staged_cnt_q != '0)
	`ASSERT_IMPLIES(a_frame_has_packet, clk, arst_n, phase_q != PH_PREAMBLE, active_len_q != '0)
	`ASSERT_IMPLIES(a_data_in_range, clk, arst_n, phase_q == PH_DATA, (CW+1)'(byte_idx) < (CW+1)'(active_len_q))
	`ASSERT_NEXT(a_tick_toggles, clk, arst_n, item_acc && item.kind == KIND_TICK, level_q != $past(level_q))
	`ASSERT_NEXT(a_result_follows, clk, arst_n, item_acc, result_valid_q)

endmodule
`default_nettype wire
